### rtl/core/frb_pkg.sv
// ----------------------------------------------------------------------------
// frb_pkg
// Shared codes and field widths of the fragment reassembly buffer.
// ----------------------------------------------------------------------------
package frb_pkg;

  localparam int KIND_W   = 2;
  localparam int ID_W     = 16;
  localparam int LEN_W    = 10;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int HELD_W   = 7;

  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_WRONG_MSG = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_DUP       = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_READ_BYTE = 3'd5;
  localparam logic [STATUS_W-1:0] STATUS_READ_END  = 3'd6;

endpackage

### rtl/core/frb_ram.sv
// ----------------------------------------------------------------------------
// frb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module frb_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/fragment_reassembly_buffer.sv
// ----------------------------------------------------------------------------
// fragment_reassembly_buffer
// Header, data and clear results are registered from EXEC; a read steps SCAN
// slot by slot, then gives the end status or, via RDWAIT, a byte. Each result
// waits while the output is stalled. One item in flight: input is taken in IDLE only.
// Reset clears the control state and the presence maps at once; slot length
// and payload RAMs are not cleared and hold data only once written.
// ----------------------------------------------------------------------------
module fragment_reassembly_buffer #(
  parameter int MAX_FRAGS  = 64,
  parameter int FRAG_BYTES = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration: message_id
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [frb_pkg::ID_W-1:0]       cfg_data_i,
  // in: msg_id[15:0] frag_id[31:16] frag_total[47:32] frag_len[57:48]
  //     data_byte[65:58], zero pad
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [frb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [frb_pkg::KIND_W-1:0]     s_axis_tuser,
  // out: out_byte[7:0] complete[8] held[15:9]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [frb_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // tuser: status[2:0]
  output logic [frb_pkg::STATUS_W-1:0]   m_axis_tuser,
  output logic                           m_axis_tlast
);

  localparam int IdxW   = $clog2(MAX_FRAGS);
  localparam int SlotW  = $clog2(MAX_FRAGS + 1);
  localparam int Depth  = MAX_FRAGS * FRAG_BYTES;
  localparam int AddrW  = $clog2(Depth);
  localparam int LenW   = frb_pkg::LEN_W;

  localparam logic [SlotW-1:0] SlotEnd    = SlotW'(MAX_FRAGS);
  localparam logic [AddrW-1:0] FragBytesA = AddrW'(FRAG_BYTES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_RDWAIT = 2'd3;

  logic [1:0] state_q, state_d;

  logic [frb_pkg::ID_W-1:0] msgid_cfg_q;

  logic [frb_pkg::KIND_W-1:0] kind_q;
  logic [frb_pkg::ID_W-1:0]   msg_q, fid_q, total_q;
  logic [LenW-1:0]            len_q;
  logic [frb_pkg::BYTE_W-1:0] byte_q;

  logic [MAX_FRAGS-1:0] present_q, present_d;
  logic [MAX_FRAGS-1:0] filled_q, filled_d;
  logic [SlotW-1:0]     held_q, held_d;
  logic                 done_q, done_d;
  logic                 fill_active_q, fill_active_d;
  logic [IdxW-1:0]      fill_slot_q, fill_slot_d;
  logic [LenW-1:0]      fill_pos_q, fill_pos_d;
  logic [LenW-1:0]      fill_len_q, fill_len_d;
  logic [SlotW-1:0]     read_slot_q, read_slot_d;
  logic [LenW-1:0]      read_pos_q, read_pos_d;
  logic                 top_valid_q, top_valid_d;
  logic [IdxW-1:0]      top_slot_q, top_slot_d;

  logic                         m_valid_q, m_valid_d;
  logic [frb_pkg::STATUS_W-1:0] status_q, status_d;
  logic [frb_pkg::BYTE_W-1:0]   obyte_q, obyte_d;
  logic                         last_q, last_d;
  logic                         complete_q, complete_d;
  logic [frb_pkg::HELD_W-1:0]   held_out_q, held_out_d;

  logic                       len_we;
  logic [IdxW-1:0]            len_waddr;
  logic [LenW-1:0]            len_wdata;
  logic [LenW-1:0]            len_rdata;
  logic                       pay_we;
  logic [AddrW-1:0]           pay_waddr;
  logic [AddrW-1:0]           pay_raddr;
  logic [frb_pkg::BYTE_W-1:0] pay_rdata;
  logic                       rd_re;

  logic            s_xfer;
  logic            out_free;
  logic [IdxW-1:0] fid_idx;
  logic [IdxW-1:0] rs_idx;
  logic            fid_ok;
  logic [LenW-1:0] len_sat;
  logic [LenW-1:0] pos_next;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign fid_idx  = fid_q[IdxW-1:0];
  assign rs_idx   = read_slot_q[IdxW-1:0];
  assign fid_ok   = (32'(fid_q) < MAX_FRAGS);
  assign len_sat  = (32'(len_q) > FRAG_BYTES) ? LenW'(FRAG_BYTES) : len_q;
  assign pos_next = read_pos_q + LenW'(1);

  assign len_waddr = fid_idx;
  assign len_wdata = len_sat;
  assign pay_waddr = AddrW'(fill_slot_q) * FragBytesA + AddrW'(fill_pos_q);
  assign pay_raddr = AddrW'(rs_idx) * FragBytesA + AddrW'(read_pos_q);

  frb_ram #(
    .Width (LenW),
    .Depth (MAX_FRAGS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .re_i    (rd_re),
    .raddr_i (rs_idx),
    .rdata_o (len_rdata)
  );

  frb_ram #(
    .Width (frb_pkg::BYTE_W),
    .Depth (Depth)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (byte_q),
    .re_i    (rd_re),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rdata)
  );

  always_comb begin
    state_d       = state_q;
    present_d     = present_q;
    filled_d      = filled_q;
    held_d        = held_q;
    done_d        = done_q;
    fill_active_d = fill_active_q;
    fill_slot_d   = fill_slot_q;
    fill_pos_d    = fill_pos_q;
    fill_len_d    = fill_len_q;
    read_slot_d   = read_slot_q;
    read_pos_d    = read_pos_q;
    top_valid_d   = top_valid_q;
    top_slot_d    = top_slot_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    status_d      = status_q;
    obyte_d       = obyte_q;
    last_d        = last_q;
    complete_d    = complete_q;
    held_out_d    = held_out_q;
    len_we        = 1'b0;
    pay_we        = 1'b0;
    rd_re         = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          state_d = (s_axis_tuser == frb_pkg::KIND_READ) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          status_d = frb_pkg::STATUS_OK;
          case (kind_q)
            frb_pkg::KIND_HEADER: begin
              fill_active_d = 1'b0;
              if (msg_q != msgid_cfg_q) begin
                status_d = frb_pkg::STATUS_WRONG_MSG;
              end else begin
                if (!fid_ok) begin
                  status_d = frb_pkg::STATUS_RANGE;
                end else if (present_q[fid_idx]) begin
                  status_d = frb_pkg::STATUS_DUP;
                end else begin
                  present_d[fid_idx] = 1'b1;
                  len_we             = 1'b1;
                  held_d             = held_q + SlotW'(1);
                  fill_active_d      = 1'b1;
                  fill_slot_d        = fid_idx;
                  fill_pos_d         = '0;
                  fill_len_d         = len_sat;
                  if (len_sat != '0) begin
                    filled_d[fid_idx] = 1'b1;
                    if (!top_valid_q || fid_idx > top_slot_q) begin
                      top_slot_d = fid_idx;
                    end
                    top_valid_d = 1'b1;
                  end
                end
                done_d = (16'(held_d) == total_q);
              end
            end
            frb_pkg::KIND_DATA: begin
              if (!fill_active_q || fill_pos_q >= fill_len_q) begin
                status_d = frb_pkg::STATUS_OVERFLOW;
              end else begin
                pay_we     = 1'b1;
                fill_pos_d = fill_pos_q + LenW'(1);
              end
            end
            default: begin
              present_d     = '0;
              filled_d      = '0;
              held_d        = '0;
              done_d        = 1'b0;
              fill_active_d = 1'b0;
              fill_slot_d   = '0;
              fill_pos_d    = '0;
              read_slot_d   = '0;
              read_pos_d    = '0;
              top_valid_d   = 1'b0;
            end
          endcase
          m_valid_d  = 1'b1;
          obyte_d    = '0;
          last_d     = 1'b0;
          complete_d = done_d;
          held_out_d = frb_pkg::HELD_W'(held_d);
          state_d    = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (read_slot_q == SlotEnd) begin
          if (out_free) begin
            read_pos_d = '0;
            m_valid_d  = 1'b1;
            status_d   = frb_pkg::STATUS_READ_END;
            obyte_d    = '0;
            last_d     = 1'b0;
            complete_d = done_q;
            held_out_d = frb_pkg::HELD_W'(held_q);
            state_d    = ST_IDLE;
          end
        end else if (filled_q[rs_idx]) begin
          rd_re   = 1'b1;
          state_d = ST_RDWAIT;
        end else begin
          read_slot_d = read_slot_q + SlotW'(1);
        end
      end
      ST_RDWAIT: begin
        if (out_free) begin
          last_d = 1'b0;
          if (pos_next >= len_rdata) begin
            read_slot_d = read_slot_q + SlotW'(1);
            read_pos_d  = '0;
            last_d      = !(top_valid_q && top_slot_q > rs_idx);
          end else begin
            read_pos_d = pos_next;
          end
          m_valid_d  = 1'b1;
          status_d   = frb_pkg::STATUS_READ_BYTE;
          obyte_d    = pay_rdata;
          complete_d = done_q;
          held_out_d = frb_pkg::HELD_W'(held_q);
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      msgid_cfg_q   <= '0;
      present_q     <= '0;
      filled_q      <= '0;
      held_q        <= '0;
      done_q        <= 1'b0;
      fill_active_q <= 1'b0;
      fill_slot_q   <= '0;
      fill_pos_q    <= '0;
      fill_len_q    <= '0;
      read_slot_q   <= '0;
      read_pos_q    <= '0;
      top_valid_q   <= 1'b0;
      top_slot_q    <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      if (cfg_valid_i) begin
        msgid_cfg_q <= cfg_data_i;
      end
      present_q     <= present_d;
      filled_q      <= filled_d;
      held_q        <= held_d;
      done_q        <= done_d;
      fill_active_q <= fill_active_d;
      fill_slot_q   <= fill_slot_d;
      fill_pos_q    <= fill_pos_d;
      fill_len_q    <= fill_len_d;
      read_slot_q   <= read_slot_d;
      read_pos_q    <= read_pos_d;
      top_valid_q   <= top_valid_d;
      top_slot_q    <= top_slot_d;
      m_valid_q     <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      kind_q  <= s_axis_tuser;
      msg_q   <= s_axis_tdata[15:0];
      fid_q   <= s_axis_tdata[31:16];
      total_q <= s_axis_tdata[47:32];
      len_q   <= s_axis_tdata[57:48];
      byte_q  <= s_axis_tdata[65:58];
    end
    status_q   <= status_d;
    obyte_q    <= obyte_d;
    last_q     <= last_d;
    complete_q <= complete_d;
    held_out_q <= held_out_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {held_out_q, complete_q, obyte_q};
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = last_q;

endmodule

### rtl/core/frb_checker.sv
// ----------------------------------------------------------------------------
// frb_checker
// Port-level checks of the fragment reassembly buffer, bound to the top.
// ----------------------------------------------------------------------------
module frb_checker #(
  parameter int MaxFrags = 64
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [frb_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic [frb_pkg::STATUS_W-1:0]   m_axis_tuser,
  input logic                           m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_last_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == frb_pkg::STATUS_READ_BYTE)
    else $error("tlast on a result that is not a read byte");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != frb_pkg::STATUS_READ_BYTE |->
      m_axis_tdata[7:0] == 8'd0 && !m_axis_tlast)
    else $error("payload byte on a non-read result");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tdata[15:9]) <= MaxFrags)
    else $error("held count above slot count");

endmodule

bind fragment_reassembly_buffer frb_checker #(.MaxFrags(MAX_FRAGS)) u_frb_checker (.*);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the fragment reassembly buffer against its own predictor. A directed
// run covers headers that are rejected, saturated lengths, stray bytes, reads
// past the end and clears. Random runs then build messages from fragments and
// read them back under random sender gaps and receiver stalls. Each run starts
// with a write of the message id.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_FRAGS  = 64;
  localparam int FRAG_BYTES = 512;

  typedef struct packed {
    logic [frb_pkg::KIND_W-1:0] kind;
    logic [frb_pkg::ID_W-1:0]   msg_id;
    logic [frb_pkg::ID_W-1:0]   frag_id;
    logic [frb_pkg::ID_W-1:0]   frag_total;
    logic [frb_pkg::LEN_W-1:0]  frag_len;
    logic [frb_pkg::BYTE_W-1:0] data_byte;
  } frag_item_t;

  typedef struct packed {
    logic [frb_pkg::STATUS_W-1:0] status;
    logic [frb_pkg::BYTE_W-1:0]   out_byte;
    logic                         last;
    logic                         complete;
    logic [frb_pkg::HELD_W-1:0]   held;
  } frag_result_t;

  class reassembly_scoreboard;
    logic [frb_pkg::ID_W-1:0]   msg_id_reg;
    bit                         present [MAX_FRAGS];
    int unsigned                slot_len [MAX_FRAGS];
    logic [frb_pkg::BYTE_W-1:0] payload [MAX_FRAGS][FRAG_BYTES];
    bit                         written [MAX_FRAGS][FRAG_BYTES];
    int unsigned                held, fill_slot, fill_pos, rd_slot, rd_pos;
    bit                         done, fill_on;
    frag_result_t               expected_q[$];
    int unsigned                n_items, n_results, errors;

    function new();
      msg_id_reg = '0;
      foreach (slot_len[i]) slot_len[i] = 0;
      n_items = 0;
      n_results = 0;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (present[i]) present[i] = 1'b0;
      held = 0;
      done = 1'b0;
      fill_on = 1'b0;
      fill_slot = 0;
      fill_pos = 0;
      rd_slot = 0;
      rd_pos = 0;
    endfunction

    function int unsigned first_filled(int unsigned s);
      while (s < MAX_FRAGS && !(present[s] && slot_len[s] != 0)) s++;
      return s;
    endfunction

    // one step of the read walk; hit is 0 when no stored byte remains
    function void walk_read(inout int unsigned rs, inout int unsigned rp, output bit hit,
                            output int unsigned slot, output int unsigned pos,
                            output bit is_last);
      hit = 1'b0;
      slot = 0;
      pos = 0;
      is_last = 1'b0;
      if (rs < MAX_FRAGS && rp >= slot_len[rs]) begin
        rs++;
        rp = 0;
      end
      rs = first_filled(rs);
      if (rs >= MAX_FRAGS) begin
        rs = MAX_FRAGS;
        rp = 0;
      end else begin
        if (rp >= FRAG_BYTES) rp = 0;
        hit = 1'b1;
        slot = rs;
        pos = rp;
        rp++;
        if (rp >= slot_len[rs]) begin
          rs++;
          rp = 0;
          is_last = (first_filled(rs) >= MAX_FRAGS);
        end
      end
    endfunction

    // true when the next read returns a byte that was actually filled or the end status
    function bit read_ok();
      int unsigned rs, rp, slot, pos;
      bit hit, is_last;
      rs = rd_slot;
      rp = rd_pos;
      walk_read(rs, rp, hit, slot, pos, is_last);
      return !hit || written[slot][pos];
    endfunction

    function void note_input(frag_item_t it);
      frag_result_t r;
      int unsigned len, slot, pos;
      bit hit, is_last;
      r = '0;
      case (it.kind)
        frb_pkg::KIND_HEADER: begin
          fill_on = 1'b0;
          if (it.msg_id != msg_id_reg) begin
            r.status = frb_pkg::STATUS_WRONG_MSG;
          end else begin
            if (32'(it.frag_id) >= MAX_FRAGS) begin
              r.status = frb_pkg::STATUS_RANGE;
            end else if (present[it.frag_id]) begin
              r.status = frb_pkg::STATUS_DUP;
            end else begin
              len = (32'(it.frag_len) > FRAG_BYTES) ? FRAG_BYTES : 32'(it.frag_len);
              present[it.frag_id] = 1'b1;
              slot_len[it.frag_id] = len;
              for (int j = 0; j < FRAG_BYTES; j++) written[it.frag_id][j] = 1'b0;
              held++;
              fill_on = 1'b1;
              fill_slot = 32'(it.frag_id);
              fill_pos = 0;
              r.status = frb_pkg::STATUS_OK;
            end
            done = (held == 32'(it.frag_total));
          end
        end
        frb_pkg::KIND_DATA: begin
          if (!fill_on || fill_pos >= slot_len[fill_slot]) begin
            r.status = frb_pkg::STATUS_OVERFLOW;
          end else begin
            payload[fill_slot][fill_pos] = it.data_byte;
            written[fill_slot][fill_pos] = 1'b1;
            fill_pos++;
            r.status = frb_pkg::STATUS_OK;
          end
        end
        frb_pkg::KIND_READ: begin
          walk_read(rd_slot, rd_pos, hit, slot, pos, is_last);
          if (hit) begin
            r.status = frb_pkg::STATUS_READ_BYTE;
            r.out_byte = payload[slot][pos];
            r.last = is_last;
          end else begin
            r.status = frb_pkg::STATUS_READ_END;
          end
        end
        default: begin
          wipe();
          r.status = frb_pkg::STATUS_OK;
        end
      endcase
      r.complete = done;
      r.held = held[frb_pkg::HELD_W-1:0];
      expected_q = {expected_q, r};
      n_items++;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(frag_result_t got);
      frag_result_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: status %0d", got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
      compare_field("last", 16'(want.last), 16'(got.last));
      compare_field("complete", 16'(want.complete), 16'(got.complete));
      compare_field("held", 16'(want.held), 16'(got.held));
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [frb_pkg::ID_W-1:0]        cfg_data_i = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [frb_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;    // msg_id, frag_id, frag_total,
                                                         // frag_len, data_byte, zero pad
  logic [frb_pkg::KIND_W-1:0]      s_axis_tuser = '0;    // kind
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [frb_pkg::M_TDATA_W-1:0]   m_axis_tdata;         // out_byte, complete, held
  logic [frb_pkg::STATUS_W-1:0]    m_axis_tuser;         // status
  logic                            m_axis_tlast;

  reassembly_scoreboard sb = new();
  int unsigned burst_left = 0;

  fragment_reassembly_buffer #(
    .MAX_FRAGS  (MAX_FRAGS),
    .FRAG_BYTES (FRAG_BYTES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  initial begin : watchdog
    #6000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic frag_item_t rand_item(input logic [frb_pkg::KIND_W-1:0] kind);
    frag_item_t it;
    it.kind = kind;
    it.msg_id = 16'($urandom);
    it.frag_id = 16'($urandom);
    it.frag_total = 16'($urandom);
    it.frag_len = 10'($urandom);
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  function automatic frag_item_t hdr_item(input logic [frb_pkg::ID_W-1:0] msg,
                                          input logic [frb_pkg::ID_W-1:0] fid,
                                          input logic [frb_pkg::ID_W-1:0] total,
                                          input logic [frb_pkg::LEN_W-1:0] len);
    frag_item_t it;
    it = rand_item(frb_pkg::KIND_HEADER);
    it.msg_id = msg;
    it.frag_id = fid;
    it.frag_total = total;
    it.frag_len = len;
    return it;
  endfunction

  // input transfer, with a random gap at the end of each burst
  task automatic offer(input frag_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, it.data_byte, it.frag_len, it.frag_total, it.frag_id, it.msg_id};
    s_axis_tuser <= it.kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_msg_id(input logic [frb_pkg::ID_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.msg_id_reg = value;
  endtask

  task automatic send_reads(input int unsigned n);
    repeat (n) if (sb.read_ok()) offer(rand_item(frb_pkg::KIND_READ));
  endtask

  // header for a free slot if one turns up, then its bytes (now and then one too many); a broken one stops short
  task automatic send_fragment(input bit broken);
    logic [frb_pkg::ID_W-1:0] fid, total;
    int unsigned len, fill, pick;
    fid = 16'($urandom_range(0, MAX_FRAGS - 1));
    repeat (4) if (sb.present[fid]) fid = 16'($urandom_range(0, MAX_FRAGS - 1));
    pick = $urandom_range(0, 9);
    if (broken) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(FRAG_BYTES + 1, 1023)
                                        : $urandom_range(2, 20);
    end else if (pick < 4) begin
      len = $urandom_range(0, 1);
    end else if (pick < 9) begin
      len = $urandom_range(2, 8);
    end else begin
      len = $urandom_range(9, 40);
    end
    case ($urandom_range(0, 3))
      0, 1: total = 16'(sb.held + 1);
      2: total = 16'($urandom);
      default: total = 16'(sb.held + $urandom_range(2, 4));
    endcase
    offer(hdr_item(sb.msg_id_reg, fid, total, 10'(len)));
    fill = (len > FRAG_BYTES) ? FRAG_BYTES : len;
    if (broken) begin
      fill = $urandom_range(0, fill - 1);
    end else if ($urandom_range(0, 9) == 0) begin
      fill++;
    end
    repeat (fill) offer(rand_item(frb_pkg::KIND_DATA));
  endtask

  task automatic send_noise();
    frag_item_t it;
    it = rand_item(frb_pkg::KIND_HEADER);
    case ($urandom_range(0, 3))
      0: if (it.msg_id == sb.msg_id_reg) it.msg_id = ~it.msg_id;
      1: begin
        it.msg_id = sb.msg_id_reg;
        it.frag_id = 16'($urandom_range(0, MAX_FRAGS - 1));
        if ($urandom_range(0, 1) != 0) it.frag_total = 16'(sb.held);
      end
      2: begin
        it.msg_id = sb.msg_id_reg;
        it.frag_id = 16'($urandom_range(MAX_FRAGS, 16'hFFFF));
        if ($urandom_range(0, 1) != 0) it.frag_total = 16'(sb.held);
      end
      default: it.kind = frb_pkg::KIND_DATA;
    endcase
    offer(it);
  endtask

  task automatic run_directed();
    frag_item_t it;
    offer(hdr_item(16'h0000, 16'd0, 16'd1, 10'd1));
    offer(hdr_item(sb.msg_id_reg, 16'hFFFF, 16'h0000, 10'd4));
    offer(hdr_item(sb.msg_id_reg, 16'd63, 16'hFFFF, 10'd2));
    it = rand_item(frb_pkg::KIND_DATA);
    it.data_byte = 8'hFF;
    offer(it);
    it.data_byte = 8'h00;
    offer(it);
    offer(rand_item(frb_pkg::KIND_DATA));
    offer(hdr_item(sb.msg_id_reg, 16'd63, 16'd1, 10'd2));
    offer(hdr_item(sb.msg_id_reg, 16'd0, 16'd2, 10'd0));
    offer(rand_item(frb_pkg::KIND_DATA));
    repeat (3) offer(rand_item(frb_pkg::KIND_READ));
    // slot behind the read pointer stays unread
    offer(hdr_item(sb.msg_id_reg, 16'd5, 16'd4, 10'd1));
    offer(rand_item(frb_pkg::KIND_DATA));
    offer(rand_item(frb_pkg::KIND_READ));
    offer(rand_item(frb_pkg::KIND_CLEAR));
    offer(rand_item(frb_pkg::KIND_DATA));
    offer(rand_item(frb_pkg::KIND_READ));
    offer(hdr_item(sb.msg_id_reg, 16'd1, 16'd1, 10'h3FF));
    repeat (3) offer(rand_item(frb_pkg::KIND_DATA));
    offer(hdr_item(16'h7FFF, 16'd1, 16'd1, 10'd1));
    offer(rand_item(frb_pkg::KIND_DATA));
    offer(rand_item(frb_pkg::KIND_CLEAR));
  endtask

  task automatic run_random(input int unsigned target, input bit big, input bit sweep);
    int unsigned start, roll, j, t, len;
    int unsigned order [MAX_FRAGS];
    if (big) begin
      offer(rand_item(frb_pkg::KIND_CLEAR));
      offer(hdr_item(sb.msg_id_reg, 16'($urandom_range(0, MAX_FRAGS - 1)), 16'($urandom),
                     10'h3FF));
      repeat ($urandom_range(4, 24)) offer(rand_item(frb_pkg::KIND_DATA));
    end
    if (sweep) begin
      // every slot once, in random order
      offer(rand_item(frb_pkg::KIND_CLEAR));
      foreach (order[i]) order[i] = i;
      for (int i = MAX_FRAGS - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
      for (int i = 0; i < MAX_FRAGS; i++) begin
        len = $urandom_range(0, 1);
        offer(hdr_item(sb.msg_id_reg, 16'(order[i]),
                       (i == MAX_FRAGS - 1 || $urandom_range(0, 1) != 0) ? 16'(i + 1)
                                                                         : 16'($urandom),
                       10'(len)));
        repeat (len) offer(rand_item(frb_pkg::KIND_DATA));
      end
    end
    start = sb.n_items;
    while (sb.n_items - start < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        send_fragment(1'b0);
      end else if (roll < 75) begin
        send_reads($urandom_range(1, 12));
      end else if (roll < 87) begin
        send_noise();
      end else if (roll < 93) begin
        send_fragment(1'b1);
      end else begin
        offer(rand_item(frb_pkg::KIND_CLEAR));
      end
    end
  endtask

  initial begin : result_sink
    int unsigned mode, mode_left, hold_left, tick;
    bit hold_done;
    frag_result_t got;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.out_byte = m_axis_tdata[7:0];
        got.complete = m_axis_tdata[8];
        got.held = m_axis_tdata[15:9];
        got.last = m_axis_tlast;
        sb.check_result(got);
      end
      if (!hold_done && sb.n_results >= 120) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= (tick % 4 == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_msg_id(16'hFFFF);
    run_directed();
    drain();
    write_msg_id(16'h0000);
    run_random(60, 1'b0, 1'b0);
    drain();
    write_msg_id(16'($urandom_range(1, 16'hFFFE)));
    run_random(40, 1'b0, 1'b1);
    drain();
    write_msg_id(16'hFFFF);
    run_random(60, 1'b1, 1'b0);
    drain();
    write_msg_id(16'($urandom_range(1, 16'hFFFE)));
    run_random(60, 1'b0, 1'b0);
    drain();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
